@@ design/awu_pkg.sv @@
// Shared constants, codes and types of the Adam weight update unit.
package awu_pkg;

   // Moment store geometry (power of two, element index is masked)
   localparam int DEPTH      = 4096;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int IDX_W      = 12;
   localparam int LR_W       = 24;

   // Control/status register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_ADAM      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 1'd1;
   localparam logic [LR_W-1:0]      LR_RESET          = 24'd16777;

   // Decay factors in Q1.31
   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
   localparam logic [31:0] BETA1   = 32'd1932735283;
   localparam logic [31:0] OMB1    = 32'd214748365;
   localparam logic [31:0] BETA2   = 32'd2145336164;
   localparam logic [31:0] OMB2    = 32'd2147484;
   localparam logic [47:0] V_MAX   = 48'hFFFF_FFFF_FFFF;

   typedef logic signed [31:0] q16_type;
   typedef logic [LR_W-1:0]    lr_type;
   typedef logic [47:0]        v_type;

   typedef struct packed {
      logic [IDX_W-1:0] element_index;
      q16_type          gradient;
      q16_type          weight_in;
      logic             update_start;
   } req_item_type;

   typedef struct packed {
      q16_type weight_out;
      logic    saturated;
   } rsp_item_type;

   // Element state after the moment update
   typedef struct packed {
      logic               adam;
      q16_type            w;
      lr_type             lr;
      logic [31:0]        d1;
      logic [31:0]        d2;
      logic signed [32:0] pd;
      q16_type            m;
      v_type              v;
      logic               sat;
   } moment_type;

endpackage

@@ design/awu_channels.sv @@
// Request and response channel interfaces of the Adam weight update unit.
interface awu_req_if;
   import awu_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] element_index;
   q16_type          gradient;
   q16_type          weight_in;
   logic             update_start;

   modport source (output valid, element_index, gradient, weight_in, update_start,
                   input ready);
   modport sink (input valid, element_index, gradient, weight_in, update_start,
                 output ready);
endinterface

interface awu_rsp_if;
   import awu_pkg::*;
   logic    valid;
   logic    ready;
   q16_type weight_out;
   logic    saturated;

   modport source (output valid, weight_out, saturated, input ready);
   modport sink (input valid, weight_out, saturated, output ready);
endinterface

@@ design/adam_weight_update_unit.sv @@
// Adam / plain gradient descent weight updater, top level (fully pipelined).
// Throughput: one element per cycle while neither the clearing pass nor a rsp stall holds the pipeline.
// Depth is set by the bit-per-stage dividers (48 stages) and square root (28 stages).
// A stalled rsp parks one result in a skid register, then holds the whole pipeline.
// Reset (synchronous): a clearing pass over all 4096 entries clears both moment stores with req.ready low;
// decay powers return to 1.0, use_adam to 1, learning_rate to 16777.
module adam_weight_update_unit (
   input  logic                            clock,
   input  logic                            reset,
   awu_req_if.sink                         req,
   awu_rsp_if.source                       rsp,
   input  logic                            csr_write_en,
   input  logic [awu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [awu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import awu_pkg::*;

   localparam int N_DIV1 = 33;
   localparam int N_DIV2 = 48;
   localparam int N_SQ   = 28;
   localparam int N_DIV3 = 48;

   // Bias-correction dividers: m_hat and v_hat
   typedef struct packed {
      logic               adam;
      q16_type            w;
      lr_type             lr;
      logic signed [32:0] pd;
      logic               sat;
      logic               msign;
      logic [31:0]        am;
      v_type              vraw;
      logic [31:0]        d1;
      logic [31:0]        d2;
      logic               d1z;
      logic               d2z;
      logic               ovf1;
      logic [31:0]        rem1;
      logic [32:0]        q1;
      logic [32:0]        src1;
      logic               ovf2;
      logic [31:0]        rem2;
      logic [47:0]        q2;
      logic [47:0]        src2;
   } div_type;

   typedef struct packed {
      logic               adam;
      q16_type            w;
      lr_type             lr;
      logic signed [32:0] pd;
      logic               sat;
      logic               msign;
      logic [31:0]        mmag;
      v_type              vhat;
   } rnd_type;

   typedef struct packed {
      logic               adam;
      q16_type            w;
      logic signed [32:0] pd;
      logic               sat;
      logic               msign;
      logic [54:0]        num;
      logic [55:0]        rem;
      logic [27:0]        root;
   } sq_type;

   typedef struct packed {
      logic               adam;
      q16_type            w;
      logic signed [32:0] pd;
      logic               sat;
      logic               msign;
      logic [28:0]        den;
      logic [28:0]        rem3;
      logic [47:0]        q3;
      logic [47:0]        src3;
   } fd_type;

   function automatic div_type div_step(div_type s, logic do1);
      logic [32:0] t1;
      logic [32:0] t2;
      div_type     r;
      r = s;
      if (do1) begin
         t1     = {s.rem1, s.src1[32]};
         r.src1 = {s.src1[31:0], 1'b0};
         if (t1 >= {1'b0, s.d1}) begin
            t1   = t1 - {1'b0, s.d1};
            r.q1 = {s.q1[31:0], 1'b1};
         end else begin
            r.q1 = {s.q1[31:0], 1'b0};
         end
         r.rem1 = t1[31:0];
      end
      t2     = {s.rem2, s.src2[47]};
      r.src2 = {s.src2[46:0], 1'b0};
      if (t2 >= {1'b0, s.d2}) begin
         t2   = t2 - {1'b0, s.d2};
         r.q2 = {s.q2[46:0], 1'b1};
      end else begin
         r.q2 = {s.q2[46:0], 1'b0};
      end
      r.rem2 = t2[31:0];
      return r;
   endfunction

   function automatic sq_type sq_step(sq_type s, int i);
      logic [56:0] trial;
      sq_type      r;
      r     = s;
      trial = (57'(s.root) << (i + 1)) + (57'(1) << (2 * i));
      if ({1'b0, s.rem} >= trial) begin
         r.rem  = s.rem - trial[55:0];
         r.root = s.root | (28'(1) << i);
      end
      return r;
   endfunction

   function automatic fd_type fd_step(fd_type s);
      logic [29:0] t;
      fd_type      r;
      r      = s;
      t      = {s.rem3, s.src3[47]};
      r.src3 = {s.src3[46:0], 1'b0};
      if (t >= {1'b0, s.den}) begin
         t    = t - {1'b0, s.den};
         r.q3 = {s.q3[46:0], 1'b1};
      end else begin
         r.q3 = {s.q3[46:0], 1'b0};
      end
      r.rem3 = t[28:0];
      return r;
   endfunction

   logic   use_adam_ff;
   lr_type lr_ff;

   logic         adv, busy, take, mo_valid;
   req_item_type item;
   moment_type   mo;

   div_type b_ff [N_DIV2];
   div_type b_in [N_DIV2];
   logic    b_v_ff [N_DIV2];
   div_type b_set;
   logic [31:0] am;
   logic [62:0] n1;

   rnd_type     r_ff, r_in;
   logic        r_v_ff;
   logic [32:0] lim1;
   logic [48:0] vq;
   logic        sat1, sat2;

   sq_type c_ff [N_SQ];
   sq_type c_in [N_SQ];
   logic   c_v_ff [N_SQ];
   sq_type c_set;
   logic [55:0] num_full;

   fd_type d_ff [N_DIV3];
   fd_type d_in [N_DIV3];
   logic   d_v_ff [N_DIV3];
   fd_type d_set;
   logic [55:0] n3;

   logic signed [49:0] delta, diff;
   logic               clip;
   rsp_item_type       fin, out_ff, skid_ff;
   logic               fin_v, out_v_ff, skid_v_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         use_adam_ff <= 1'b1;
         lr_ff       <= LR_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_USE_ADAM:      use_adam_ff <= csr_wdata[0];
            CSR_LEARNING_RATE: lr_ff       <= csr_wdata[LR_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the pipeline moves while the skid register is free
   assign adv       = !skid_v_ff;
   assign req.ready = adv && !busy;
   assign take      = req.valid && req.ready;

   assign item.element_index = req.element_index;
   assign item.gradient      = req.gradient;
   assign item.weight_in     = req.weight_in;
   assign item.update_start  = req.update_start;

   awu_moment_unit u_moment (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .take     (take),
      .item     (item),
      .use_adam (use_adam_ff),
      .lr       (lr_ff),
      .busy     (busy),
      .mo_valid (mo_valid),
      .mo       (mo)
   );

   // Divider setup: numerators |m|*2^31 + d1/2 and v*2^31, overflow pre-check
   always_comb begin
      am = mo.m[31] ? (~mo.m + 32'd1) : mo.m;
      n1 = {am, 31'b0} + 63'(mo.d1 >> 1);
      b_set.adam  = mo.adam;
      b_set.w     = mo.w;
      b_set.lr    = mo.lr;
      b_set.pd    = mo.pd;
      b_set.sat   = mo.sat;
      b_set.msign = mo.m[31];
      b_set.am    = am;
      b_set.vraw  = mo.v;
      b_set.d1    = mo.d1;
      b_set.d2    = mo.d2;
      b_set.d1z   = (mo.d1 == 32'd0);
      b_set.d2z   = (mo.d2 == 32'd0);
      b_set.ovf1  = ({2'b0, n1[62:33]} >= mo.d1);
      b_set.rem1  = {2'b0, n1[62:33]};
      b_set.q1    = '0;
      b_set.src1  = n1[32:0];
      b_set.ovf2  = ({1'b0, mo.v[47:17]} >= mo.d2);
      b_set.rem2  = {1'b0, mo.v[47:17]};
      b_set.q2    = '0;
      b_set.src2  = {mo.v[16:0], 31'b0};
   end

   // One v_hat quotient bit per stage; m_hat quotient bits only in the first N_DIV1 stages
   always_comb begin
      for (int k = 0; k < N_DIV2; k++) begin
         b_in[k] = div_step((k == 0) ? b_set : b_ff[k - 1], k < N_DIV1);
      end
   end

   // Rounding and saturation of m_hat and v_hat
   always_comb begin
      lim1 = b_ff[N_DIV2-1].msign ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      sat1 = 1'b0;
      sat2 = 1'b0;
      r_in.adam  = b_ff[N_DIV2-1].adam;
      r_in.w     = b_ff[N_DIV2-1].w;
      r_in.lr    = b_ff[N_DIV2-1].lr;
      r_in.pd    = b_ff[N_DIV2-1].pd;
      r_in.msign = b_ff[N_DIV2-1].msign;
      if (b_ff[N_DIV2-1].d1z) begin
         r_in.mmag = b_ff[N_DIV2-1].am;
      end else if (b_ff[N_DIV2-1].ovf1 || (b_ff[N_DIV2-1].q1 > lim1)) begin
         r_in.mmag = lim1[31:0];
         sat1      = 1'b1;
      end else begin
         r_in.mmag = b_ff[N_DIV2-1].q1[31:0];
      end
      vq = {1'b0, b_ff[N_DIV2-1].q2}
         + 49'({b_ff[N_DIV2-1].rem2, 1'b0} >= {1'b0, b_ff[N_DIV2-1].d2});
      if (b_ff[N_DIV2-1].d2z) begin
         r_in.vhat = b_ff[N_DIV2-1].vraw;
      end else if (b_ff[N_DIV2-1].ovf2 || vq[48]) begin
         r_in.vhat = V_MAX;
         sat2      = 1'b1;
      end else begin
         r_in.vhat = vq[47:0];
      end
      r_in.sat = b_ff[N_DIV2-1].sat | (b_ff[N_DIV2-1].adam & (sat1 | sat2));
   end

   // Square root setup, numerator |m_hat| * lr alongside
   always_comb begin
      num_full    = 56'(r_ff.mmag) * 56'(r_ff.lr);
      c_set.adam  = r_ff.adam;
      c_set.w     = r_ff.w;
      c_set.pd    = r_ff.pd;
      c_set.sat   = r_ff.sat;
      c_set.msign = r_ff.msign;
      c_set.num   = num_full[54:0];
      c_set.rem   = {r_ff.vhat, 8'b0};
      c_set.root  = '0;
   end

   // One root bit per stage
   always_comb begin
      for (int k = 0; k < N_SQ; k++) begin
         c_in[k] = sq_step((k == 0) ? c_set : c_ff[k - 1], N_SQ - 1 - k);
      end
   end

   // Step divider setup: (num + den*128) / 256 over den
   always_comb begin
      d_set.adam  = c_ff[N_SQ-1].adam;
      d_set.w     = c_ff[N_SQ-1].w;
      d_set.pd    = c_ff[N_SQ-1].pd;
      d_set.sat   = c_ff[N_SQ-1].sat;
      d_set.msign = c_ff[N_SQ-1].msign;
      d_set.den   = {1'b0, c_ff[N_SQ-1].root} + 29'd1;
      n3          = {1'b0, c_ff[N_SQ-1].num} + 56'({d_set.den, 7'b0});
      d_set.src3  = n3[55:8];
      d_set.rem3  = '0;
      d_set.q3    = '0;
   end

   always_comb begin
      for (int k = 0; k < N_DIV3; k++) begin
         d_in[k] = fd_step((k == 0) ? d_set : d_ff[k - 1]);
      end
   end

   // Weight update and final saturation
   always_comb begin
      if (d_ff[N_DIV3-1].adam) begin
         delta = d_ff[N_DIV3-1].msign ? -$signed({2'b0, d_ff[N_DIV3-1].q3})
                                      :  $signed({2'b0, d_ff[N_DIV3-1].q3});
      end else begin
         delta = {{17{d_ff[N_DIV3-1].pd[32]}}, d_ff[N_DIV3-1].pd};
      end
      diff  = $signed({{18{d_ff[N_DIV3-1].w[31]}}, d_ff[N_DIV3-1].w}) - delta;
      clip  = (diff[49:31] != '0) && (diff[49:31] != '1);
      fin.weight_out = clip ? (diff[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : diff[31:0];
      fin.saturated  = d_ff[N_DIV3-1].sat | clip;
      fin_v          = d_v_ff[N_DIV3-1];
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N_DIV2; k++) b_v_ff[k] <= 1'b0;
         for (int k = 0; k < N_SQ; k++)   c_v_ff[k] <= 1'b0;
         for (int k = 0; k < N_DIV3; k++) d_v_ff[k] <= 1'b0;
         r_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff[0] <= mo_valid;
         for (int k = 1; k < N_DIV2; k++) b_v_ff[k] <= b_v_ff[k - 1];
         r_v_ff    <= b_v_ff[N_DIV2-1];
         c_v_ff[0] <= r_v_ff;
         for (int k = 1; k < N_SQ; k++)   c_v_ff[k] <= c_v_ff[k - 1];
         d_v_ff[0] <= c_v_ff[N_SQ-1];
         for (int k = 1; k < N_DIV3; k++) d_v_ff[k] <= d_v_ff[k - 1];
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < N_DIV2; k++) b_ff[k] <= b_in[k];
         r_ff <= r_in;
         for (int k = 0; k < N_SQ; k++)   c_ff[k] <= c_in[k];
         for (int k = 0; k < N_DIV3; k++) d_ff[k] <= d_in[k];
      end
   end

   // Output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp.ready) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || rsp.ready) begin
         out_v_ff <= fin_v;
      end else if (fin_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp.ready) begin
            out_ff <= skid_ff;
         end
      end else if (!out_v_ff || rsp.ready) begin
         out_ff <= fin;
      end else begin
         skid_ff <= fin;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.weight_out = out_ff.weight_out;
   assign rsp.saturated  = out_ff.saturated;

endmodule

@@ design/awu_moment_unit.sv @@
// Moment stores, decay powers and the per-element moment read-modify-write.
module awu_moment_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  take,
   input  awu_pkg::req_item_type item,
   input  logic                  use_adam,
   input  awu_pkg::lr_type       lr,
   output logic                  busy,
   output logic                  mo_valid,
   output awu_pkg::moment_type   mo
);
   import awu_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] idx;
      q16_type           g;
      q16_type           w;
      logic              adam;
      lr_type            lr;
      logic [31:0]       d1;
      logic [31:0]       d2;
   } s0_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  idx;
      q16_type            w;
      logic               adam;
      lr_type             lr;
      logic [31:0]        d1;
      logic [31:0]        d2;
      logic signed [59:0] gterm;
      v_type              g2s;
      logic signed [32:0] pd;
      logic               sat;
   } s1_type;

   logic [31:0]       p1_ff, p2_ff, p1_nx, p2_nx, p1_use, p2_use;
   logic [63:0]       p1_prod, p2_prod;
   logic              busy_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic   s0_v_ff, s1_v_ff, s2_v_ff;
   s0_type s0_ff, s0_in;
   s1_type s1_ff, s1_in;
   moment_type        s2_ff, s2_in;
   logic [ADDR_W-1:0] s2_idx_ff;

   q16_type mem_m [DEPTH];
   v_type   mem_v [DEPTH];
   q16_type rd_m_ff;
   v_type   rd_v_ff;

   // S0 -> S1 precompute
   logic [31:0]        ag;
   logic [63:0]        sq, sq_r;
   logic signed [63:0] gt_full, pd_full;

   // S1 moment update
   logic               fwd, wr_en;
   q16_type            m_old, m_new;
   v_type              v_old, v_new;
   logic signed [63:0] mprod, mx;
   logic [32:0]        msh;
   logic [55:0]        va, vb;
   logic [69:0]        vt;
   logic [79:0]        vx;
   logic               m_sat, v_sat;

   assign busy     = busy_ff;
   assign mo_valid = s2_v_ff;
   assign mo       = s2_ff;

   // Decay power advance on the first element of a pass in Adam mode
   assign p1_prod = 64'(p1_ff) * 64'(BETA1);
   assign p2_prod = 64'(p2_ff) * 64'(BETA2);
   assign p1_nx   = p1_prod[62:31];
   assign p2_nx   = p2_prod[62:31];
   assign p1_use  = (use_adam && item.update_start) ? p1_nx : p1_ff;
   assign p2_use  = (use_adam && item.update_start) ? p2_nx : p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= ONE_Q31;
         p2_ff <= ONE_Q31;
      end else if (take) begin
         p1_ff <= p1_use;
         p2_ff <= p2_use;
      end
   end

   // Clearing pass over both stores after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Accept stage
   always_comb begin
      s0_in.idx  = item.element_index[ADDR_W-1:0];
      s0_in.g    = item.gradient;
      s0_in.w    = item.weight_in;
      s0_in.adam = use_adam;
      s0_in.lr   = lr;
      s0_in.d1   = ONE_Q31 - p1_use;
      s0_in.d2   = ONE_Q31 - p2_use;
   end

   // Gradient terms: g*(1-beta1), rounded g^2, plain step
   always_comb begin
      ag      = s0_ff.g[31] ? (~s0_ff.g + 32'd1) : s0_ff.g;
      sq      = 64'(ag) * 64'(ag);
      sq_r    = sq + 64'd128;
      gt_full = $signed({{32{s0_ff.g[31]}}, s0_ff.g}) * $signed({32'b0, OMB1});
      pd_full = $signed({{32{s0_ff.g[31]}}, s0_ff.g}) * $signed({40'b0, s0_ff.lr})
              + 64'sh80_0000;
      s1_in.idx   = s0_ff.idx;
      s1_in.w     = s0_ff.w;
      s1_in.adam  = s0_ff.adam;
      s1_in.lr    = s0_ff.lr;
      s1_in.d1    = s0_ff.d1;
      s1_in.d2    = s0_ff.d2;
      s1_in.gterm = gt_full[59:0];
      s1_in.pd    = pd_full[56:24];
      s1_in.sat   = 1'b0;
      if (sq_r[63:56] != 8'd0) begin
         s1_in.g2s = V_MAX;
         s1_in.sat = s0_ff.adam;
      end else begin
         s1_in.g2s = sq_r[55:8];
      end
   end

   // Moment update, forwarding the previous element's result on an index match
   always_comb begin
      fwd   = s2_v_ff && s2_ff.adam && (s2_idx_ff == s1_ff.idx);
      m_old = fwd ? s2_ff.m : rd_m_ff;
      v_old = fwd ? s2_ff.v : rd_v_ff;

      mprod = $signed({{32{m_old[31]}}, m_old}) * $signed({32'b0, BETA1});
      mx    = mprod + $signed({{4{s1_ff.gterm[59]}}, s1_ff.gterm}) + 64'sh4000_0000;
      msh   = mx[63:31];
      m_sat = (msh[32] != msh[31]);
      m_new = m_sat ? (msh[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : msh[31:0];

      va    = 56'(v_old[47:24]) * 56'(BETA2);
      vb    = 56'(v_old[23:0]) * 56'(BETA2);
      vt    = 70'(s1_ff.g2s) * 70'(OMB2);
      vx    = {va, 24'b0} + 80'(vb) + 80'(vt) + 80'h4000_0000;
      v_sat = vx[79];
      v_new = v_sat ? V_MAX : vx[78:31];

      s2_in.adam = s1_ff.adam;
      s2_in.w    = s1_ff.w;
      s2_in.lr   = s1_ff.lr;
      s2_in.d1   = s1_ff.d1;
      s2_in.d2   = s1_ff.d2;
      s2_in.pd   = s1_ff.pd;
      s2_in.m    = m_new;
      s2_in.v    = v_new;
      s2_in.sat  = s1_ff.sat | (s1_ff.adam & (m_sat | v_sat));
   end

   assign wr_en = adv && s1_v_ff && s1_ff.adam;

   // Moment stores: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem_m[clr_cnt_ff] <= '0;
         mem_v[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem_m[s1_ff.idx] <= m_new;
         mem_v[s1_ff.idx] <= v_new;
      end
      if (adv) begin
         rd_m_ff <= mem_m[s0_ff.idx];
         rd_v_ff <= mem_v[s0_ff.idx];
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= take;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff     <= s0_in;
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         s2_idx_ff <= s1_ff.idx;
      end
   end

endmodule
